### src/bbcg_pkg.sv
// Shared constants for the block buffer cache: result codes, buffer status
// codes, field widths and parameter defaults. No dependencies.
package bbcg_pkg;

    localparam int NUM_BUFFERS_DEF  = 64;
    localparam int HASH_BUCKETS_DEF = 4;

    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int IDX_W = 6;

    localparam logic [2:0] RES_HIT      = 3'd0;
    localparam logic [2:0] RES_MISS     = 3'd1;
    localparam logic [2:0] RES_BUSY     = 3'd2;
    localparam logic [2:0] RES_NONE     = 3'd3;
    localparam logic [2:0] RES_FLUSH    = 3'd4;
    localparam logic [2:0] RES_RELEASED = 3'd5;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_DIRTY   = 2'd2;
    localparam logic [1:0] ST_BUSY    = 2'd3;

    localparam logic KIND_GET     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

endpackage

### src/bbcg_mod.sv
// Remainder of a block number by the bucket count through a reciprocal multiplication,
// with the dividend, product and remainder registered in turn. Depends on bbcg_pkg.
module bbcg_mod #(
    parameter int HASH_BUCKETS = bbcg_pkg::HASH_BUCKETS_DEF,
    parameter int HW           = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bbcg_pkg::BLK_W-1:0] dividend,
    output logic                      done,
    output logic [HW-1:0]             rem
);

    localparam int BW = bbcg_pkg::BLK_W;
    localparam int PW = 2 * BW + 1;
    localparam int SH = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 0;
    // ceil(2^(BW+SH) / HASH_BUCKETS) gives an exact quotient for every BW-bit dividend
    localparam logic [BW:0] RECIP = (BW+1)'(((64'd1 << (BW + SH)) + 64'(HASH_BUCKETS)
                                             - 64'd1) / 64'(HASH_BUCKETS));

    logic [BW-1:0] div_reg;
    logic [PW-1:0] prod_reg;
    logic [HW-1:0] rem_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic          done_reg;
    logic [BW-1:0] quot;
    logic [BW-1:0] qmul;
    logic [HW-1:0] rem_next;

    always_comb
    begin
        quot     = BW'(prod_reg >> (BW + SH));
        qmul     = quot * BW'(HASH_BUCKETS);
        rem_next = div_reg[HW-1:0] - qmul[HW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            div_reg <= dividend;
        prod_reg <= PW'(div_reg) * PW'(RECIP);
        if (v2_reg)
            rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

### src/block_buffer_cache_getblk.sv
// Block buffer cache top level: buffer record memory, bucket head memory,
// free list head and count, and the sequencer. Depends on bbcg_pkg, bbcg_mod.

// One item at a time. After reset a clearing pass initializes both memories
// before the first beat is taken. A release with an out-of-range index goes
// straight to the result; one whose buffer is not busy or whose free list was
// empty goes to the result after the busy check, and any other first links the
// buffer into the free list between the head and its predecessor. A get
// computes the bucket remainder (reciprocal multiplication), reads the bucket
// head and walks the hash chain with one read of the record memory and one
// compare per entry visited; unless the buffer is busy or the free list is
// empty, it then unlinks the buffer from the free list, retags a clean victim
// and registers the result. A clean victim that was hashed adds a second
// remainder, a bucket read and a second chain walk to unhash it. The next input
// beat is taken once the result beat is registered, and a result beat that is
// still waiting holds the block.
module block_buffer_cache_getblk #(
    parameter int NUM_BUFFERS  = bbcg_pkg::NUM_BUFFERS_DEF,
    parameter int HASH_BUCKETS = bbcg_pkg::HASH_BUCKETS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [bbcg_pkg::DEV_W-1:0]  device_number,
    input  logic [bbcg_pkg::BLK_W-1:0]  block_number,
    input  logic [bbcg_pkg::IDX_W-1:0]  buffer_index,
    input  logic [1:0]                  release_status,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  result_code,
    output logic [bbcg_pkg::IDX_W-1:0]  granted_buffer,
    output logic                        contents_valid,
    output logic [bbcg_pkg::DEV_W-1:0]  victim_device,
    output logic [bbcg_pkg::BLK_W-1:0]  victim_block
);

    localparam int IW   = $clog2(NUM_BUFFERS);
    localparam int LW   = IW + 1;
    localparam int HW   = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
    localparam int MAXN = (NUM_BUFFERS > HASH_BUCKETS) ? NUM_BUFFERS : HASH_BUCKETS;
    localparam int CW   = $clog2(MAXN) + 1;
    localparam logic [LW-1:0] NONE = LW'(NUM_BUFFERS);

    typedef struct packed {
        logic [bbcg_pkg::DEV_W-1:0] dev;
        logic [bbcg_pkg::BLK_W-1:0] blk;
        logic                       present;
        logic [1:0]                 st;
        logic [IW-1:0]              fnext;
        logic [IW-1:0]              fprev;
        logic [LW-1:0]              cnext;
    } ent_t;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MODW, S_BKT, S_WALK, S_WCHK, S_VRD,
        S_ULK, S_UWP, S_URN, S_UWN, S_POST, S_UMOD, S_UBKT, S_UWALK, S_UCHK,
        S_RB, S_RBW, S_RCHK, S_RF, S_RT, S_RF2, S_RWF, S_RWB, S_OUT
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              clr_reg;
    logic [LW-1:0]              free_first_reg;
    logic [LW-1:0]              free_count_reg;
    logic [LW-1:0]              cur_reg;
    logic [LW-1:0]              steps_reg;
    logic [IW-1:0]              b_reg;
    logic [IW-1:0]              t_reg;
    logic [HW-1:0]              key_reg;
    logic [HW-1:0]              ukey_reg;
    logic                       op_hit_reg;
    logic [1:0]                 ns_reg;
    ent_t                       tgt_reg;
    logic [bbcg_pkg::DEV_W-1:0] dev_reg;
    logic [bbcg_pkg::BLK_W-1:0] blk_reg;

    logic [2:0]                 res_code_reg;
    logic [bbcg_pkg::IDX_W-1:0] res_grant_reg;
    logic                       res_valid_reg;
    logic [bbcg_pkg::DEV_W-1:0] res_vdev_reg;
    logic [bbcg_pkg::BLK_W-1:0] res_vblk_reg;

    logic                       out_valid_reg;
    logic [2:0]                 out_code_reg;
    logic [bbcg_pkg::IDX_W-1:0] out_grant_reg;
    logic                       out_cv_reg;
    logic [bbcg_pkg::DEV_W-1:0] out_vdev_reg;
    logic [bbcg_pkg::BLK_W-1:0] out_vblk_reg;

    ent_t                       ent_mem [NUM_BUFFERS];
    logic [LW-1:0]              bkt_mem [HASH_BUCKETS];
    ent_t                       ent_rdata_reg;
    logic [LW-1:0]              bkt_rdata_reg;

    logic                       ent_we;
    logic [IW-1:0]              ent_waddr;
    ent_t                       ent_wdata;
    logic [IW-1:0]              ent_raddr;
    logic                       bkt_we;
    logic [HW-1:0]              bkt_waddr;
    logic [LW-1:0]              bkt_wdata;
    logic [HW-1:0]              bkt_raddr;

    logic                       mod_start;
    logic [bbcg_pkg::BLK_W-1:0] mod_dividend;
    logic                       mod_done;
    logic [HW-1:0]              mod_rem;

    logic                       accept;
    logic                       idx_in_range;
    logic [IW-1:0]              idx_addr;
    logic [1:0]                 in_ns;
    logic                       list_empty;
    logic                       walk_go;
    logic                       tag_match;
    logic                       out_free;
    ent_t                       init_ent;
    ent_t                       rel_ent;

    assign accept       = in_valid && (state_reg == S_IDLE);
    assign in_stall     = (state_reg != S_IDLE);
    assign idx_in_range = (32'(buffer_index) < 32'(NUM_BUFFERS));
    assign idx_addr     = IW'(32'(buffer_index));
    assign in_ns        = (release_status == 2'd3) ? bbcg_pkg::ST_INVALID : release_status;
    assign list_empty   = (free_count_reg == '0) || (free_first_reg >= NONE);
    assign walk_go      = (cur_reg < NONE) && (steps_reg < NONE);
    assign tag_match    = ent_rdata_reg.present && (ent_rdata_reg.dev == dev_reg)
                          && (ent_rdata_reg.blk == blk_reg);
    assign out_free     = !out_valid_reg || !out_stall;

    assign mod_start    = (accept && (kind == bbcg_pkg::KIND_GET))
                          || ((state_reg == S_POST) && !op_hit_reg
                              && (tgt_reg.st != bbcg_pkg::ST_DIRTY) && tgt_reg.present);
    assign mod_dividend = (state_reg == S_IDLE) ? block_number : tgt_reg.blk;

    bbcg_mod #(
        .HASH_BUCKETS(HASH_BUCKETS),
        .HW          (HW)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .dividend(mod_dividend),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    always_comb
    begin
        init_ent         = '0;
        init_ent.cnext   = NONE;
        init_ent.fnext   = (clr_reg == CW'(NUM_BUFFERS - 1)) ? '0 : IW'(clr_reg + CW'(1));
        init_ent.fprev   = (clr_reg == '0) ? IW'(NUM_BUFFERS - 1) : IW'(clr_reg - CW'(1));
    end

    always_comb
    begin
        rel_ent    = ent_rdata_reg;
        rel_ent.st = ns_reg;
    end

    // memory port control
    always_comb
    begin
        ent_we    = 1'b0;
        ent_waddr = b_reg;
        ent_wdata = ent_rdata_reg;
        ent_raddr = b_reg;
        bkt_we    = 1'b0;
        bkt_waddr = key_reg;
        bkt_wdata = NONE;
        bkt_raddr = key_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ent_we    = (clr_reg < CW'(NUM_BUFFERS));
                ent_waddr = IW'(clr_reg);
                ent_wdata = init_ent;
                bkt_we    = (clr_reg < CW'(HASH_BUCKETS));
                bkt_waddr = HW'(clr_reg);
            end
            S_IDLE:  ent_raddr = idx_addr;
            S_MODW:  bkt_raddr = mod_rem;
            S_WALK:  ent_raddr = walk_go ? IW'(cur_reg) : IW'(free_first_reg);
            S_ULK:   ent_raddr = tgt_reg.fprev;
            S_UWP:
            begin
                ent_we          = 1'b1;
                ent_waddr       = tgt_reg.fprev;
                ent_wdata.fnext = tgt_reg.fnext;
            end
            S_URN:   ent_raddr = tgt_reg.fnext;
            S_UWN:
            begin
                ent_we          = 1'b1;
                ent_waddr       = tgt_reg.fnext;
                ent_wdata.fprev = tgt_reg.fprev;
            end
            S_POST:
            begin
                ent_we       = op_hit_reg || (tgt_reg.st == bbcg_pkg::ST_DIRTY);
                ent_wdata    = tgt_reg;
                ent_wdata.st = bbcg_pkg::ST_BUSY;
            end
            S_UMOD:  bkt_raddr = mod_rem;
            S_UBKT:
            begin
                bkt_we    = (bkt_rdata_reg == {1'b0, b_reg});
                bkt_waddr = ukey_reg;
                bkt_wdata = tgt_reg.cnext;
            end
            S_UWALK: ent_raddr = IW'(cur_reg);
            S_UCHK:
            begin
                ent_we          = (ent_rdata_reg.cnext == {1'b0, b_reg});
                ent_waddr       = IW'(cur_reg);
                ent_wdata.cnext = tgt_reg.cnext;
            end
            S_RB:    bkt_raddr = key_reg;
            S_RBW:
            begin
                ent_we            = 1'b1;
                ent_wdata         = tgt_reg;
                ent_wdata.dev     = dev_reg;
                ent_wdata.blk     = blk_reg;
                ent_wdata.present = 1'b1;
                ent_wdata.st      = bbcg_pkg::ST_BUSY;
                ent_wdata.cnext   = bkt_rdata_reg;
                bkt_we            = 1'b1;
                bkt_wdata         = {1'b0, b_reg};
            end
            S_RCHK:
            begin
                ent_raddr       = IW'(free_first_reg);
                ent_we          = (ent_rdata_reg.st == bbcg_pkg::ST_BUSY) && list_empty;
                ent_wdata.st    = ns_reg;
                ent_wdata.fnext = b_reg;
                ent_wdata.fprev = b_reg;
            end
            S_RF:    ent_raddr = ent_rdata_reg.fprev;
            S_RT:
            begin
                ent_we          = 1'b1;
                ent_waddr       = t_reg;
                ent_wdata.fnext = b_reg;
            end
            S_RF2:   ent_raddr = IW'(free_first_reg);
            S_RWF:
            begin
                ent_we          = 1'b1;
                ent_waddr       = IW'(free_first_reg);
                ent_wdata.fprev = b_reg;
            end
            S_RWB:
            begin
                ent_we          = 1'b1;
                ent_wdata       = tgt_reg;
                ent_wdata.fprev = t_reg;
                ent_wdata.fnext = IW'(free_first_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[ent_waddr] <= ent_wdata;
        ent_rdata_reg <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_waddr] <= bkt_wdata;
        bkt_rdata_reg <= bkt_mem[bkt_raddr];
    end

    // sequencer, free list head and count, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            free_first_reg <= '0;
            free_count_reg <= LW'(NUM_BUFFERS);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == CW'(MAXN - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        dev_reg       <= device_number;
                        blk_reg       <= block_number;
                        b_reg         <= idx_addr;
                        ns_reg        <= in_ns;
                        res_valid_reg <= 1'b0;
                        res_vdev_reg  <= '0;
                        res_vblk_reg  <= '0;
                        if (kind == bbcg_pkg::KIND_GET)
                        begin
                            res_code_reg  <= bbcg_pkg::RES_HIT;
                            res_grant_reg <= '0;
                            state_reg     <= S_MODW;
                        end
                        else
                        begin
                            res_code_reg  <= bbcg_pkg::RES_RELEASED;
                            res_grant_reg <= buffer_index;
                            state_reg     <= idx_in_range ? S_RCHK : S_OUT;
                        end
                    end
                end
                S_MODW:
                begin
                    if (mod_done)
                    begin
                        key_reg   <= mod_rem;
                        state_reg <= S_BKT;
                    end
                end
                S_BKT:
                begin
                    cur_reg   <= bkt_rdata_reg;
                    steps_reg <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    if (walk_go)
                        state_reg <= S_WCHK;
                    else if (list_empty)
                    begin
                        res_code_reg <= bbcg_pkg::RES_NONE;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        b_reg         <= IW'(free_first_reg);
                        res_grant_reg <= bbcg_pkg::IDX_W'(IW'(free_first_reg));
                        state_reg     <= S_VRD;
                    end
                end
                S_WCHK:
                begin
                    if (tag_match)
                    begin
                        b_reg         <= IW'(cur_reg);
                        tgt_reg       <= ent_rdata_reg;
                        res_grant_reg <= bbcg_pkg::IDX_W'(IW'(cur_reg));
                        if (ent_rdata_reg.st == bbcg_pkg::ST_BUSY)
                        begin
                            res_code_reg <= bbcg_pkg::RES_BUSY;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            res_code_reg  <= bbcg_pkg::RES_HIT;
                            res_valid_reg <= (ent_rdata_reg.st != bbcg_pkg::ST_INVALID);
                            op_hit_reg    <= 1'b1;
                            state_reg     <= S_ULK;
                        end
                    end
                    else
                    begin
                        cur_reg   <= ent_rdata_reg.cnext;
                        steps_reg <= steps_reg + LW'(1);
                        state_reg <= S_WALK;
                    end
                end
                S_VRD:
                begin
                    tgt_reg    <= ent_rdata_reg;
                    op_hit_reg <= 1'b0;
                    state_reg  <= S_ULK;
                end
                S_ULK:
                begin
                    if (free_count_reg <= LW'(1))
                    begin
                        free_first_reg <= NONE;
                        free_count_reg <= '0;
                        state_reg      <= S_POST;
                    end
                    else
                    begin
                        if (free_first_reg == {1'b0, b_reg})
                            free_first_reg <= {1'b0, tgt_reg.fnext};
                        free_count_reg <= free_count_reg - LW'(1);
                        state_reg      <= S_UWP;
                    end
                end
                S_UWP:   state_reg <= S_URN;
                S_URN:   state_reg <= S_UWN;
                S_UWN:   state_reg <= S_POST;
                S_POST:
                begin
                    if (op_hit_reg)
                        state_reg <= S_OUT;
                    else if (tgt_reg.st == bbcg_pkg::ST_DIRTY)
                    begin
                        res_code_reg <= bbcg_pkg::RES_FLUSH;
                        res_vdev_reg <= tgt_reg.dev;
                        res_vblk_reg <= tgt_reg.blk;
                        state_reg    <= S_OUT;
                    end
                    else
                    begin
                        res_code_reg <= bbcg_pkg::RES_MISS;
                        state_reg    <= tgt_reg.present ? S_UMOD : S_RB;
                    end
                end
                S_UMOD:
                begin
                    if (mod_done)
                    begin
                        ukey_reg  <= mod_rem;
                        state_reg <= S_UBKT;
                    end
                end
                S_UBKT:
                begin
                    cur_reg   <= bkt_rdata_reg;
                    steps_reg <= '0;
                    state_reg <= (bkt_rdata_reg == {1'b0, b_reg}) ? S_RB : S_UWALK;
                end
                S_UWALK: state_reg <= walk_go ? S_UCHK : S_RB;
                S_UCHK:
                begin
                    if (ent_rdata_reg.cnext == {1'b0, b_reg})
                        state_reg <= S_RB;
                    else
                    begin
                        cur_reg   <= ent_rdata_reg.cnext;
                        steps_reg <= steps_reg + LW'(1);
                        state_reg <= S_UWALK;
                    end
                end
                S_RB:    state_reg <= S_RBW;
                S_RBW:   state_reg <= S_OUT;
                S_RCHK:
                begin
                    if (ent_rdata_reg.st != bbcg_pkg::ST_BUSY)
                        state_reg <= S_OUT;
                    else
                    begin
                        res_valid_reg <= (ns_reg != bbcg_pkg::ST_INVALID);
                        tgt_reg       <= rel_ent;
                        if (list_empty)
                        begin
                            free_first_reg <= {1'b0, b_reg};
                            free_count_reg <= LW'(1);
                            state_reg      <= S_OUT;
                        end
                        else
                            state_reg <= S_RF;
                    end
                end
                S_RF:
                begin
                    t_reg     <= ent_rdata_reg.fprev;
                    state_reg <= S_RT;
                end
                S_RT:    state_reg <= S_RF2;
                S_RF2:   state_reg <= S_RWF;
                S_RWF:   state_reg <= S_RWB;
                S_RWB:
                begin
                    // invalid or dirty goes to the head, valid stays at the tail
                    if (ns_reg != bbcg_pkg::ST_VALID)
                        free_first_reg <= {1'b0, b_reg};
                    free_count_reg <= free_count_reg + LW'(1);
                    state_reg      <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_code_reg  <= res_code_reg;
                        out_grant_reg <= res_grant_reg;
                        out_cv_reg    <= res_valid_reg;
                        out_vdev_reg  <= res_vdev_reg;
                        out_vblk_reg  <= res_vblk_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_code    = out_code_reg;
    assign granted_buffer = out_grant_reg;
    assign contents_valid = out_cv_reg;
    assign victim_device  = out_vdev_reg;
    assign victim_block   = out_vblk_reg;

endmodule
